@@ hdl/affine_point_transform_macros.svh @@
// ============================================================================
// Assertion macros for the affine point transform
// Concurrent check wrappers that compile away when SYNTHESIS is defined.
// ============================================================================
`ifndef AFFINE_POINT_TRANSFORM_MACROS_SVH
`define AFFINE_POINT_TRANSFORM_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define APT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");
// Next-cycle implication, disabled while reset is asserted.
`define APT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");
`else
`define APT_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define APT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/apt_pkg.sv @@
// ============================================================================
// Affine point transform package
// Word types, action codes and widths shared by the transform pipeline.
// ============================================================================
package apt_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int COEF_N        = 12;
    localparam int AXES          = 3;
    localparam int HALF_W        = DATA_W / 2;
    localparam int HIGH_W        = DATA_W - HALF_W;
    localparam int PL_W          = DATA_W + HALF_W + 1;
    localparam int PH_W          = DATA_W + HIGH_W;
    localparam int PROD_W        = 2 * DATA_W;

    localparam logic [DATA_W-1:0] COORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] COORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ACT_LOAD_FWD  = 2'd0,
        ACT_LOAD_INV  = 2'd1,
        ACT_XFORM_FWD = 2'd2,
        ACT_XFORM_INV = 2'd3
    } t_action;

    typedef struct packed {
        t_action                   action;
        logic [1:0]                coef_row;
        logic [1:0]                coef_col;
        logic signed [DATA_W-1:0]  coef_value;
        logic signed [DATA_W-1:0]  point_x;
        logic signed [DATA_W-1:0]  point_y;
        logic signed [DATA_W-1:0]  point_z;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0]  out_x;
        logic signed [DATA_W-1:0]  out_y;
        logic signed [DATA_W-1:0]  out_z;
        logic                      overflow;
    } t_out_word;

    typedef logic [COEF_N-1:0][DATA_W-1:0] t_coef_set;
    typedef logic [AXES-1:0][DATA_W-1:0]   t_point;

    typedef struct packed {
        t_point    pt;
        t_coef_set coefs;
    } t_s1_word;

    typedef struct packed {
        logic [AXES*AXES-1:0][PROD_W-1:0] prod;
        logic [AXES-1:0][DATA_W-1:0]      trans;
    } t_prod_word;

endpackage

@@ hdl/apt_coef_store.sv @@
// ============================================================================
// Coefficient store
// Forward and inverse matrices, reset to identity, with a matrix select.
// ============================================================================
module apt_coef_store import apt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_load_inv,
    input  logic [1:0]        i_row,
    input  logic [1:0]        i_col,
    input  logic [DATA_W-1:0] i_value,
    input  logic              i_sel_inv,
    output t_coef_set         o_coefs
);

    // One in fixed point; shifts out to zero when it does not fit the word.
    localparam logic [DATA_W-1:0] IDENT = {{(DATA_W-1){1'b0}}, 1'b1} << FRAC_BITS;

    t_coef_set r_fwd;
    t_coef_set r_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < COEF_N; i++) begin
                r_fwd[i] <= (i % 4 == 0) ? IDENT : '0;
                r_inv[i] <= (i % 4 == 0) ? IDENT : '0;
            end
        end else if (i_load) begin
            // A column of three matches no entry, so such a load is dropped.
            for (int i = 0; i < COEF_N; i++) begin
                if (i_row == 2'(i / 3) && i_col == 2'(i % 3)) begin
                    if (i_load_inv) begin
                        r_inv[i] <= i_value;
                    end else begin
                        r_fwd[i] <= i_value;
                    end
                end
            end
        end
    end

    assign o_coefs = i_sel_inv ? r_inv : r_fwd;

endmodule

@@ hdl/apt_mult.sv @@
// ============================================================================
// Product stages
// Split half-word partial products, then their recombination.
// ============================================================================
module apt_mult import apt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_s1_word   i_word,
    output logic       o_valid,
    input  logic       i_ready,
    output t_prod_word o_word
);

    logic                      r_v2;
    logic signed [PL_W-1:0]    r_pl [AXES*AXES];
    logic signed [PH_W-1:0]    r_ph [AXES*AXES];
    logic [AXES-1:0][DATA_W-1:0] r_trans2;
    logic signed [PL_W-1:0]    n_pl [AXES*AXES];
    logic signed [PH_W-1:0]    n_ph [AXES*AXES];

    logic                      r_v3;
    t_prod_word                r_word3;
    t_prod_word                n_word3;

    logic en2;
    logic en3;

    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign o_ready = en2;

    // Entry e = row*3 + col multiplies point coordinate row by coefficient e.
    // The coefficient is split into an unsigned low half and a signed high half.
    always_comb begin
        logic signed [PL_W-1:0] a_l, b_l;
        logic signed [PH_W-1:0] a_h, b_h;
        for (int e = 0; e < AXES * AXES; e++) begin
            a_l = PL_W'($signed(i_word.pt[e / 3]));
            b_l = PL_W'($signed({1'b0, i_word.coefs[e][HALF_W-1:0]}));
            a_h = PH_W'($signed(i_word.pt[e / 3]));
            b_h = PH_W'($signed(i_word.coefs[e][DATA_W-1:HALF_W]));
            n_pl[e] = a_l * b_l;
            n_ph[e] = a_h * b_h;
        end
    end

    always_comb begin
        for (int e = 0; e < AXES * AXES; e++) begin
            n_word3.prod[e] = (PROD_W'(r_ph[e]) <<< HALF_W) + PROD_W'(r_pl[e]);
        end
        n_word3.trans = r_trans2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en2) begin
                r_v2 <= i_valid;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && i_valid) begin
            r_pl     <= n_pl;
            r_ph     <= n_ph;
            r_trans2 <= i_word.coefs[COEF_N-1:COEF_N-AXES];
        end
        if (en3 && r_v2) begin
            r_word3 <= n_word3;
        end
    end

    assign o_valid = r_v3;
    assign o_word  = r_word3;

endmodule

@@ hdl/apt_accum.sv @@
// ============================================================================
// Accumulate and saturate stages
// Pairwise sums, final sum, then shift and clip into the output word.
// ============================================================================
module apt_accum import apt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_prod_word i_word,
    output logic       o_valid,
    input  logic       i_stall,
    output t_out_word  o_word
);

    localparam int WIDE_W = (PROD_W > DATA_W + FRAC_BITS) ? PROD_W : DATA_W + FRAC_BITS;
    localparam int SUM_W  = WIDE_W + 2;

    logic                    r_v4;
    logic signed [SUM_W-1:0] r_pa [AXES];
    logic signed [SUM_W-1:0] r_pb [AXES];
    logic signed [SUM_W-1:0] n_pa [AXES];
    logic signed [SUM_W-1:0] n_pb [AXES];

    logic                    r_v5;
    logic signed [SUM_W-1:0] r_sum [AXES];

    logic                    r_out_v;
    t_out_word               r_out;
    logic [DATA_W-1:0]       n_coord [AXES];
    logic                    n_ovf;

    logic en4;
    logic en5;
    logic en_out;

    assign en_out  = !r_out_v || !i_stall;
    assign en5     = !r_v5 || en_out;
    assign en4     = !r_v4 || en5;
    assign o_ready = en4;

    // Rows 0 and 1 in one adder, row 2 plus the aligned translation in the other.
    always_comb begin
        for (int c = 0; c < AXES; c++) begin
            n_pa[c] = SUM_W'($signed(i_word.prod[c])) + SUM_W'($signed(i_word.prod[3 + c]));
            n_pb[c] = SUM_W'($signed(i_word.prod[6 + c]))
                    + (SUM_W'($signed(i_word.trans[c])) <<< FRAC_BITS);
        end
    end

    // The arithmetic shift floors; a value fits when its upper bits are all one sign.
    always_comb begin
        logic signed [SUM_W-1:0]    sh;
        logic [SUM_W-DATA_W:0]      top;
        n_ovf = 1'b0;
        for (int c = 0; c < AXES; c++) begin
            sh  = r_sum[c] >>> FRAC_BITS;
            top = sh[SUM_W-1:DATA_W-1];
            if ((&top) || !(|top)) begin
                n_coord[c] = sh[DATA_W-1:0];
            end else begin
                n_coord[c] = sh[SUM_W-1] ? COORD_MIN : COORD_MAX;
                n_ovf      = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4    <= 1'b0;
            r_v5    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (en4) begin
                r_v4 <= i_valid;
            end
            if (en5) begin
                r_v5 <= r_v4;
            end
            if (en_out) begin
                r_out_v <= r_v5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4 && i_valid) begin
            r_pa <= n_pa;
            r_pb <= n_pb;
        end
        if (en5 && r_v4) begin
            for (int c = 0; c < AXES; c++) begin
                r_sum[c] <= r_pa[c] + r_pb[c];
            end
        end
        if (en_out && r_v5) begin
            r_out.out_x    <= n_coord[0];
            r_out.out_y    <= n_coord[1];
            r_out.out_z    <= n_coord[2];
            r_out.overflow <= n_ovf;
        end
    end

    assign o_valid = r_out_v;
    assign o_word  = r_out;

endmodule

@@ hdl/affine_point_transform.sv @@
// Structure: six register stages, from the point capture through to the output register.
// Throughput: one word per cycle while no stall holds the pipeline; every stage has
//   its own valid bit, so bubbles close up under a stall and input is still taken while
//   a finished result waits at the output.
// Load words update a coefficient at the edge they are accepted and produce no result.
// Reset (synchronous, active low) empties the pipeline and sets both matrices to identity.
// ============================================================================
// Affine point transform
// Applies a stored forward or inverse 3D affine matrix to Q16.16 points.
// ============================================================================
`include "affine_point_transform_macros.svh"

module affine_point_transform import apt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    // Stage one captures the point together with the twelve coefficients of the
    // selected matrix. Taking a copy here means later loads cannot disturb a
    // transform already in flight, and a load followed at once by a transform
    // is seen by that transform.
    logic      r_s1_valid;
    t_s1_word  r_s1;
    t_s1_word  n_s1;
    t_coef_set sel_coefs;

    logic accept;
    logic is_load;
    logic s1_en;
    logic mult_ready;

    logic       prod_valid;
    logic       accum_ready;
    t_prod_word prod_word;

    // High when some output coordinate sits at either end of the signed range.
    logic out_at_limit;

    assign is_load    = (i_in_word.action == ACT_LOAD_FWD) ||
                        (i_in_word.action == ACT_LOAD_INV);
    assign s1_en      = !r_s1_valid || mult_ready;
    assign o_in_stall = !s1_en;
    assign accept     = i_in_valid && s1_en;

    apt_coef_store #(
        .FRAC_BITS (FRAC_BITS)
    ) u_coef_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept && is_load),
        .i_load_inv (i_in_word.action == ACT_LOAD_INV),
        .i_row      (i_in_word.coef_row),
        .i_col      (i_in_word.coef_col),
        .i_value    (i_in_word.coef_value),
        .i_sel_inv  (i_in_word.action == ACT_XFORM_INV),
        .o_coefs    (sel_coefs)
    );

    always_comb begin
        n_s1.pt    = {i_in_word.point_z, i_in_word.point_y, i_in_word.point_x};
        n_s1.coefs = sel_coefs;
    end

    // Only transform words enter the pipeline; a load leaves a bubble behind.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_en) begin
            r_s1_valid <= accept && !is_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !is_load) begin
            r_s1 <= n_s1;
        end
    end

    // Stages two and three: partial products and their recombination.
    apt_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .o_ready (mult_ready),
        .i_word  (r_s1),
        .o_valid (prod_valid),
        .i_ready (accum_ready),
        .o_word  (prod_word)
    );

    // Stages four to six: pair sums, full sum, then shift and saturation into
    // the output register.
    apt_accum #(
        .FRAC_BITS (FRAC_BITS)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prod_valid),
        .o_ready (accum_ready),
        .i_word  (prod_word),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (o_out_word)
    );

    assign out_at_limit = (o_out_word.out_x == COORD_MAX) || (o_out_word.out_x == COORD_MIN) ||
                          (o_out_word.out_y == COORD_MAX) || (o_out_word.out_y == COORD_MIN) ||
                          (o_out_word.out_z == COORD_MAX) || (o_out_word.out_z == COORD_MIN);

    // A stall at the input only ever comes from a full first stage.
    `APT_ASSERT_NOW(a_stall_needs_s1, i_clk, i_rst_n, o_in_stall, r_s1_valid)
    // A load word never occupies a pipeline slot.
    `APT_ASSERT_NEXT(a_load_no_slot, i_clk, i_rst_n, accept && is_load, !r_s1_valid)
    // A transform word always lands in the first stage.
    `APT_ASSERT_NEXT(a_xform_slot, i_clk, i_rst_n, accept && !is_load, r_s1_valid)
    // An overflow flag comes with at least one clipped coordinate.
    `APT_ASSERT_NOW(a_ovf_clipped, i_clk, i_rst_n, o_out_valid && o_out_word.overflow, out_at_limit)

endmodule

@@ tb/sv/affine_point_transform_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Affine point transform testbench
// Streams coefficient loads and forward/inverse point transforms into the
// block with random gaps and output back-pressure. A behavioral Q16.16 model
// tracks both matrices and predicts every result word in order.
// ============================================================================
module affine_point_transform_tb import apt_pkg::*; ();

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int FRAC           = FRAC_BITS_DEF;
    localparam int ACC_W          = 2 * DATA_W + 16;
    localparam int ROW_TRANS      = 3;
    localparam int RANDOM_WORDS   = 500;
    localparam int MAX_GAP        = 19;
    localparam int LONG_HOLD      = 400;
    localparam int LONG_HOLD_AT   = 60;
    localparam int DRAIN_CYCLES   = 32;
    localparam int WATCHDOG_LIMIT = 2000;

    // One queued input word together with the idle cycles that follow it.
    typedef struct {
        t_in_word    word;
        int unsigned gap;
    } t_send_slot;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    // Words waiting to be offered, and results predicted but not yet seen.
    t_send_slot pending_words[$];
    t_out_word  predicted_points[$];

    // The predictor's own copy of both matrices, indexed row * 3 + col.
    t_coef_set fwd_matrix;
    t_coef_set inv_matrix;

    // Handshake flags from the last rising edge, read by the falling-edge drivers.
    logic in_taken  = 1'b0;
    logic out_taken = 1'b0;

    int unsigned mismatch_count  = 0;
    int unsigned points_received = 0;
    int unsigned quiet_cycles    = 0;
    int unsigned gap_left        = 0;
    int unsigned stall_left      = 0;
    logic        long_hold_done  = 1'b0;

    affine_point_transform #(
        .FRAC_BITS(FRAC)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Applies one matrix to the point in a transform word. Each axis sums the
    // three products and the translation (scaled up by the fraction width) at
    // full precision, shifts right arithmetically (so fractions round toward
    // minus infinity), and clips to the signed coordinate range.
    function automatic t_out_word apply_matrix(input t_coef_set m, input t_in_word w);
        t_out_word                r;
        logic signed [ACC_W-1:0]  pt [AXES];
        logic signed [ACC_W-1:0]  acc;
        logic signed [DATA_W-1:0] coord [AXES];
        logic                     clipped;
        pt[0] = $signed(w.point_x);
        pt[1] = $signed(w.point_y);
        pt[2] = $signed(w.point_z);
        clipped = 1'b0;
        for (int c = 0; c < AXES; c++) begin
            acc = $signed(m[ROW_TRANS * AXES + c]);
            acc = acc <<< FRAC;
            for (int k = 0; k < AXES; k++) begin
                acc = acc + pt[k] * $signed(m[k * AXES + c]);
            end
            acc = acc >>> FRAC;
            // The sum fits only if every bit above the coordinate's sign bit
            // copies the sign; otherwise it clips toward the sign of the sum.
            if (acc[ACC_W-1:DATA_W-1] != {(ACC_W - DATA_W + 1){acc[ACC_W-1]}}) begin
                coord[c] = acc[ACC_W-1] ? COORD_MIN : COORD_MAX;
                clipped = 1'b1;
            end else begin
                coord[c] = acc[DATA_W-1:0];
            end
        end
        r.out_x = coord[0];
        r.out_y = coord[1];
        r.out_z = coord[2];
        r.overflow = clipped;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h got %h", $realtime, name, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic signed [DATA_W-1:0] to_fixed(input real v);
        return $rtoi(v * (2.0 ** FRAC));
    endfunction

    // Mostly values within a few units so that sums stay in range, with a
    // share of full-range values and the two extremes to force clipping.
    function automatic logic signed [DATA_W-1:0] rand_fixed();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return COORD_MAX;
            3:       return COORD_MIN;
            4:       return $urandom_range(0, 1) ? to_fixed(1.0) : to_fixed(-1.0);
            default: return $urandom_range(0, 2 ** 21) - 2 ** 20;
        endcase
    endfunction

    // Point fields of a load are don't-care, so they carry random bits.
    function automatic t_in_word load_word(input t_action act, input int row, input int col,
                                           input logic signed [DATA_W-1:0] value);
        t_in_word w;
        w.action     = act;
        w.coef_row   = 2'(row);
        w.coef_col   = 2'(col);
        w.coef_value = value;
        w.point_x    = $urandom;
        w.point_y    = $urandom;
        w.point_z    = $urandom;
        return w;
    endfunction

    // Coefficient fields of a transform are don't-care as well.
    function automatic t_in_word xform_word(input t_action act,
                                            input logic signed [DATA_W-1:0] x,
                                            input logic signed [DATA_W-1:0] y,
                                            input logic signed [DATA_W-1:0] z);
        t_in_word w;
        w.action     = act;
        w.coef_row   = 2'($urandom);
        w.coef_col   = 2'($urandom);
        w.coef_value = $urandom;
        w.point_x    = x;
        w.point_y    = y;
        w.point_z    = z;
        return w;
    endfunction

    // Every third stretch of 40 words goes back to back; the rest get random gaps.
    task automatic queue_word(input t_in_word w);
        t_send_slot slot;
        slot.word = w;
        slot.gap  = ((pending_words.size() / 40) % 3 == 2) ? 0 : $urandom_range(0, MAX_GAP);
        pending_words.push_back(slot);
    endtask

    // ------------------------------------------------------------------------
    // Input driver: changes the input word at the falling edge. A word stays
    // on the bus until the rising edge accepts it, then the idle gap drawn
    // for it runs out before the next word is offered.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic       next_valid;
        t_in_word   next_word;
        t_send_slot slot;
        next_valid = i_in_valid;
        next_word  = i_in_word;
        if (i_rst_n) begin
            if (i_in_valid && in_taken) begin
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_words.size() > 0) begin
                    slot       = pending_words.pop_front();
                    next_word  = slot.word;
                    next_valid = 1'b1;
                    gap_left   = slot.gap;
                end
            end
        end
        i_in_valid <= next_valid;
        i_in_word  <= next_word;
    end

    // ------------------------------------------------------------------------
    // Output receiver: after each result word it draws how long to hold off
    // the next one. One long hold-off lets the pipeline fill up completely so
    // that the block has to stall its input while words keep being offered.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic next_stall;
        if (out_taken) begin
            if (points_received == LONG_HOLD_AT && !long_hold_done) begin
                stall_left     = LONG_HOLD;
                long_hold_done = 1'b1;
            end else if ((points_received / 40) % 3 == 1) begin
                stall_left = 0;
            end else begin
                stall_left = $urandom_range(0, MAX_GAP);
            end
        end
        if (stall_left > 0) begin
            next_stall = 1'b1;
            stall_left--;
        end else begin
            next_stall = 1'b0;
        end
        i_out_stall <= next_stall;
    end

    // ------------------------------------------------------------------------
    // Monitor: at each rising edge it records both handshakes, keeps the
    // predicted matrices in step with accepted loads, queues a prediction for
    // every accepted transform and checks each result word against the oldest
    // prediction. It also runs the watchdog on cycles with no traffic.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_in_word  w;
        t_out_word want;
        logic      in_acc;
        logic      out_acc;
        int        idx;
        in_acc  = i_rst_n && i_in_valid && !o_in_stall;
        out_acc = i_rst_n && o_out_valid && !i_out_stall;
        in_taken  <= in_acc;
        out_taken <= out_acc;

        if (out_acc) begin
            points_received++;
            if (predicted_points.size() == 0) begin
                $display("%0t: unexpected result word, expected none got %h",
                         $realtime, o_out_word);
                mismatch_count++;
            end else begin
                want = predicted_points.pop_front();
                compare_field("out_x", want.out_x, o_out_word.out_x);
                compare_field("out_y", want.out_y, o_out_word.out_y);
                compare_field("out_z", want.out_z, o_out_word.out_z);
                compare_field("overflow", DATA_W'(want.overflow), DATA_W'(o_out_word.overflow));
            end
        end

        if (in_acc) begin
            w   = i_in_word;
            idx = int'(w.coef_row) * AXES + int'(w.coef_col);
            case (w.action)
                ACT_LOAD_FWD: begin
                    // A load aimed at the column past z is dropped.
                    if (w.coef_col < AXES) fwd_matrix[idx] = w.coef_value;
                end
                ACT_LOAD_INV: begin
                    if (w.coef_col < AXES) inv_matrix[idx] = w.coef_value;
                end
                ACT_XFORM_FWD: begin
                    predicted_points.push_back(apply_matrix(fwd_matrix, w));
                end
                ACT_XFORM_INV: begin
                    predicted_points.push_back(apply_matrix(inv_matrix, w));
                end
                default: begin
                end
            endcase
        end

        if (in_acc || out_acc) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $realtime, quiet_cycles);
            $display("affine_point_transform regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int action_pick;
        int col;

        // Both matrices come out of reset as the identity.
        for (int i = 0; i < COEF_N; i++) begin
            fwd_matrix[i] = (i < AXES * AXES && i / AXES == i % AXES) ?
                            (DATA_W'(1) << FRAC) : '0;
            inv_matrix[i] = fwd_matrix[i];
        end

        // Identity on both matrices, then the coordinate extremes.
        queue_word(xform_word(ACT_XFORM_FWD, to_fixed(1.5), to_fixed(-2.25), to_fixed(3.0)));
        queue_word(xform_word(ACT_XFORM_INV, rand_fixed(), rand_fixed(), rand_fixed()));
        queue_word(xform_word(ACT_XFORM_FWD, COORD_MAX, COORD_MAX, COORD_MAX));
        queue_word(xform_word(ACT_XFORM_INV, COORD_MIN, COORD_MIN, COORD_MIN));

        // Translation row, then a load to the nonexistent fourth column, which
        // must leave the matrix untouched.
        queue_word(load_word(ACT_LOAD_FWD, ROW_TRANS, 0, to_fixed(10.0)));
        queue_word(load_word(ACT_LOAD_FWD, ROW_TRANS, 1, to_fixed(-3.5)));
        queue_word(load_word(ACT_LOAD_FWD, ROW_TRANS, 2, to_fixed(0.25)));
        queue_word(xform_word(ACT_XFORM_FWD, to_fixed(2.0), to_fixed(-1.0), to_fixed(0.5)));
        queue_word(load_word(ACT_LOAD_FWD, 0, 3, COORD_MAX));
        queue_word(xform_word(ACT_XFORM_FWD, to_fixed(2.0), to_fixed(-1.0), to_fixed(0.5)));

        // Saturation on x only: positive, negative, and the min times min case.
        queue_word(load_word(ACT_LOAD_FWD, 0, 0, COORD_MAX));
        queue_word(xform_word(ACT_XFORM_FWD, COORD_MAX, to_fixed(1.0), to_fixed(1.0)));
        queue_word(xform_word(ACT_XFORM_FWD, COORD_MIN, to_fixed(1.0), to_fixed(1.0)));
        queue_word(load_word(ACT_LOAD_FWD, 0, 0, COORD_MIN));
        queue_word(xform_word(ACT_XFORM_FWD, COORD_MIN, 0, 0));

        // Inverse matrix with cross terms, and an ignored inverse load.
        queue_word(load_word(ACT_LOAD_INV, 1, 2, to_fixed(-2.0)));
        queue_word(load_word(ACT_LOAD_INV, 2, 1, to_fixed(0.5)));
        queue_word(load_word(ACT_LOAD_INV, ROW_TRANS, 2, to_fixed(-1.0)));
        queue_word(load_word(ACT_LOAD_INV, 3, 3, COORD_MIN));
        queue_word(xform_word(ACT_XFORM_INV, to_fixed(4.0), to_fixed(-3.0), to_fixed(7.75)));
        queue_word(xform_word(ACT_XFORM_INV, '1, '1, '1));

        // A half-weight times the smallest negative step truncates downward.
        queue_word(load_word(ACT_LOAD_FWD, 0, 0, to_fixed(1.0)));
        queue_word(load_word(ACT_LOAD_FWD, 1, 1, to_fixed(0.5)));
        queue_word(xform_word(ACT_XFORM_FWD, 0, '1, 0));

        // Random part: mostly transforms on a matrix that a steady trickle of
        // loads keeps changing; about one load in eight targets the dead column.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            action_pick = $urandom_range(0, 9);
            if (action_pick < 3) begin
                col = ($urandom_range(0, 7) == 0) ? 3 : $urandom_range(0, AXES - 1);
                queue_word(load_word(($urandom_range(0, 1) != 0) ? ACT_LOAD_INV : ACT_LOAD_FWD,
                                     $urandom_range(0, ROW_TRANS), col, rand_fixed()));
            end else begin
                queue_word(xform_word(($urandom_range(0, 1) != 0) ? ACT_XFORM_INV
                                                                  : ACT_XFORM_FWD,
                                      rand_fixed(), rand_fixed(), rand_fixed()));
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every word to be accepted and every prediction to be met,
        // then give the pipeline time to show any stray result.
        while (pending_words.size() != 0 || i_in_valid || predicted_points.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("affine_point_transform regression: pass");
        end else begin
            $display("affine_point_transform regression: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/apt_pkg.sv
hdl/apt_coef_store.sv
hdl/apt_mult.sv
hdl/apt_accum.sv
hdl/affine_point_transform.sv
tb/sv/affine_point_transform_tb.sv
